// ===== rtl/mrpd_pkg.sv =====
package mrpd_pkg;

  localparam int MAX_CPUS = 4;
  localparam int CPU_W    = 2;
  localparam int PRIO_W   = 7;
  localparam int OP_W     = 2;
  localparam int ROWS     = 8;

  localparam logic [PRIO_W-1:0] NO_RT     = 7'd64;
  localparam logic [3:0]        MASK_INIT = 4'hF;

  typedef enum logic [OP_W-1:0] {
    OP_READY  = 2'd0,
    OP_SLEEP  = 2'd1,
    OP_REPORT = 2'd2,
    OP_SCHED  = 2'd3
  } op_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;     // snapshot ready map, clear scratch
    logic             apply;    // execute ready / sleep / report
    logic             extract;  // take next highest ready level
    logic             match;    // settle one CPU
    logic [CPU_W-1:0] step;     // CPU the current step works on
  } ctl_t;

  // lowest set bit of a byte
  function automatic logic [2:0] low_bit8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (v[b]) r = 3'(b);
    end
    return r;
  endfunction

endpackage

// ===== rtl/mrpd_cmd_if.sv =====
interface mrpd_cmd_if;
  import mrpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [PRIO_W-1:0] prio;
  logic [CPU_W-1:0]  cpu;

  modport source (output valid, output opcode, output prio, output cpu, input ready);
  modport sink   (input valid, input opcode, input prio, input cpu, output ready);
endinterface

// ===== rtl/mrpd_disp_if.sv =====
interface mrpd_disp_if;
  import mrpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CPU_W-1:0]  cpu_index;
  logic [PRIO_W-1:0] chosen_prio;
  logic              needs_resched;
  logic              is_realtime;
  logic              last;

  modport source (output valid, output cpu_index, output chosen_prio, output needs_resched,
                  output is_realtime, output last, input ready);
  modport sink   (input valid, input cpu_index, input chosen_prio, input needs_resched,
                  input is_realtime, input last, output ready);
endinterface

// ===== rtl/mrpd_ctrl.sv =====
module mrpd_ctrl #(
  parameter int NCPU = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [mrpd_pkg::OP_W-1:0] in_opcode,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mrpd_pkg::ctl_t            ctl
);
  import mrpd_pkg::*;

  localparam logic [CPU_W-1:0] LAST = CPU_W'(NCPU - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXTRACT,
    S_MATCH,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CPU_W-1:0] step;
  logic             accept;
  logic             is_sched;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign accept    = in_valid && in_ready;
  assign is_sched  = (in_opcode == OP_SCHED);

  // command decode
  always_comb begin
    ctl.load    = accept && is_sched;
    ctl.apply   = accept && !is_sched;
    ctl.extract = (state == S_EXTRACT);
    ctl.match   = (state == S_MATCH);
    ctl.step    = step;
  end

  // sequencer: extract, match, emit, one CPU per step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && is_sched) begin
            state <= S_EXTRACT;
            step  <= '0;
          end
        end
        S_EXTRACT: begin
          if (step == LAST) begin
            state <= S_MATCH;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_MATCH: begin
          if (step == LAST) begin
            state <= S_EMIT;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (step == LAST) begin
              state <= S_IDLE;
              step  <= '0;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
          step  <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mrpd_datapath.sv =====
module mrpd_datapath #(
  parameter int NCPU = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [3:0]                  cfg_data,
  input  mrpd_pkg::ctl_t              ctl,
  input  logic [mrpd_pkg::OP_W-1:0]   opcode,
  input  logic [mrpd_pkg::PRIO_W-1:0] prio,
  input  logic [mrpd_pkg::CPU_W-1:0]  cpu,
  output logic [mrpd_pkg::CPU_W-1:0]  cpu_index,
  output logic [mrpd_pkg::PRIO_W-1:0] chosen_prio,
  output logic                        needs_resched,
  output logic                        is_realtime,
  output logic                        last
);
  import mrpd_pkg::*;

  localparam logic [CPU_W-1:0] LAST = CPU_W'(NCPU - 1);

  // architectural state
  logic [3:0]        global_cpu_mask;
  logic [7:0]        ready_group;
  logic [7:0]        ready_rows [ROWS];
  logic [PRIO_W-1:0] current_prio [MAX_CPUS];

  // schedule scratch
  logic [7:0]        work_group;
  logic [7:0]        work_rows [ROWS];
  logic [5:0]        slot [MAX_CPUS];
  logic [MAX_CPUS-1:0] slot_valid;
  logic [MAX_CPUS-1:0] taken;
  logic [MAX_CPUS-1:0] settled;
  logic [PRIO_W-1:0] chosen [MAX_CPUS];

  // op decode
  logic [2:0] op_y, op_x;
  logic [7:0] op_bit, sleep_row;
  assign op_y      = prio[5:3];
  assign op_x      = prio[2:0];
  assign op_bit    = 8'b1 << op_x;
  assign sleep_row = ready_rows[op_y] & ~op_bit;

  // extraction of the next highest ready level
  logic [2:0] ext_y, ext_x;
  logic [7:0] ext_row_clr;
  logic       ext_take;
  assign ext_y       = low_bit8(work_group);
  assign ext_x       = low_bit8(work_rows[ext_y]);
  assign ext_row_clr = work_rows[ext_y] & ~(8'b1 << ext_x);
  assign ext_take    = global_cpu_mask[ctl.step] && (work_group != 8'd0);

  // matching for the CPU at ctl.step
  logic [MAX_CPUS-1:0] blocked, kept_hit, free_hit;
  logic [CPU_W-1:0]    kept_j, free_j;
  logic                kept_any, free_any;
  logic [PRIO_W-1:0]   cur_step;
  assign cur_step = current_prio[ctl.step];

  always_comb begin
    for (int j = 0; j < MAX_CPUS; j++) begin
      blocked[j] = 1'b0;
      for (int m = 0; m < NCPU; m++) begin
        if (!settled[m] && current_prio[m] == {1'b0, slot[j]}) blocked[j] = 1'b1;
      end
      kept_hit[j] = slot_valid[j] && !taken[j] && (cur_step == {1'b0, slot[j]});
      free_hit[j] = slot_valid[j] && !taken[j] && !blocked[j];
    end
    kept_any = 1'b0;
    free_any = 1'b0;
    kept_j   = '0;
    free_j   = '0;
    // descending so the lowest index wins
    for (int j = MAX_CPUS - 1; j >= 0; j--) begin
      if (kept_hit[j]) begin
        kept_any = 1'b1;
        kept_j   = CPU_W'(j);
      end
      if (free_hit[j]) begin
        free_any = 1'b1;
        free_j   = CPU_W'(j);
      end
    end
  end

  // ready map, running priorities, config
  always_ff @(posedge clk) begin
    if (rst) begin
      global_cpu_mask <= MASK_INIT;
      ready_group     <= '0;
      for (int i = 0; i < ROWS; i++) ready_rows[i] <= '0;
      for (int i = 0; i < MAX_CPUS; i++) current_prio[i] <= NO_RT;
    end else begin
      if (cfg_we) global_cpu_mask <= cfg_data;
      if (ctl.apply) begin
        case (opcode)
          OP_READY: begin
            if (!prio[6]) begin
              ready_group[op_y] <= 1'b1;
              ready_rows[op_y]  <= ready_rows[op_y] | op_bit;
            end
          end
          OP_SLEEP: begin
            if (!prio[6]) begin
              ready_rows[op_y] <= sleep_row;
              if (sleep_row == 8'd0) ready_group[op_y] <= 1'b0;
            end
          end
          OP_REPORT: begin
            if (int'(cpu) < NCPU) current_prio[cpu] <= (prio > NO_RT) ? NO_RT : prio;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // schedule scratch: snapshot, extraction, matching
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work_group <= ready_group;
      for (int i = 0; i < ROWS; i++) work_rows[i] <= ready_rows[i];
      for (int i = 0; i < MAX_CPUS; i++) begin
        slot_valid[i] <= 1'b0;
        taken[i]      <= (i < NCPU) && !global_cpu_mask[i];
        settled[i]    <= (i < NCPU) && !global_cpu_mask[i];
        chosen[i]     <= NO_RT;
      end
    end else if (ctl.extract) begin
      if (ext_take) begin
        slot[ctl.step]       <= {ext_y, ext_x};
        slot_valid[ctl.step] <= 1'b1;
        work_rows[ext_y]     <= ext_row_clr;
        if (ext_row_clr == 8'd0) work_group[ext_y] <= 1'b0;
      end
    end else if (ctl.match) begin
      if (global_cpu_mask[ctl.step]) begin
        if (kept_any) begin
          chosen[ctl.step]  <= cur_step;
          taken[kept_j]     <= 1'b1;
          settled[ctl.step] <= 1'b1;
        end else if (free_any) begin
          chosen[ctl.step] <= {1'b0, slot[free_j]};
          taken[free_j]    <= 1'b1;
        end
      end
    end
  end

  // result fields for the CPU being emitted
  assign cpu_index     = ctl.step;
  assign chosen_prio   = chosen[ctl.step];
  assign needs_resched = (chosen[ctl.step] != cur_step);
  assign is_realtime   = !chosen[ctl.step][6];
  assign last          = (ctl.step == LAST);

endmodule

// ===== rtl/multicore_realtime_priority_dispatcher_top.sv =====
// Real-time priority dispatcher for up to four CPUs over 64 levels (0 highest).
// Ready, sleep and report items complete in the cycle they are accepted and
// produce nothing. A schedule item runs extraction (the next highest ready
// level for each CPU whose mask bit is set, while any remain, from a snapshot
// of the group/row map), then matching (one CPU settled per cycle), then
// returns NCPU results, one per cycle while the sink takes them. The step
// sequencer works one CPU at a time; cmd.ready is low from a schedule item's
// acceptance until its last result is taken. NCPU is NUM_CPUS capped at four.
// Local CPUs (mask bit 0) always receive level 64.
module multicore_realtime_priority_dispatcher_top #(
  parameter int NUM_CPUS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  mrpd_cmd_if.sink    cmd,
  mrpd_disp_if.source dispatch
);
  import mrpd_pkg::*;

  localparam int NCPU = (NUM_CPUS < MAX_CPUS) ? NUM_CPUS : MAX_CPUS;

  ctl_t ctl;

  mrpd_ctrl #(.NCPU(NCPU)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_opcode (cmd.opcode),
    .in_ready  (cmd.ready),
    .out_valid (dispatch.valid),
    .out_ready (dispatch.ready),
    .ctl       (ctl)
  );

  mrpd_datapath #(.NCPU(NCPU)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .ctl           (ctl),
    .opcode        (cmd.opcode),
    .prio          (cmd.prio),
    .cpu           (cmd.cpu),
    .cpu_index     (dispatch.cpu_index),
    .chosen_prio   (dispatch.chosen_prio),
    .needs_resched (dispatch.needs_resched),
    .is_realtime   (dispatch.is_realtime),
    .last          (dispatch.last)
  );

endmodule

// ===== rtl/mrpd_checker.sv =====
module mrpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] cpu_index,
  input logic [6:0] chosen_prio,
  input logic       is_realtime,
  input logic       last
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chosen_prio) && $stable(cpu_index))
    else $error("stalled result changed");

  // no new item is taken while results are pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted during result burst");

  // results walk the CPUs in order
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && cpu_index == 2'($past(cpu_index) + 2'd1))
    else $error("cpu_index out of order");

  // level range and real-time flag agree
  a_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> chosen_prio <= 7'd64 && is_realtime == (chosen_prio < 7'd64))
    else $error("bad chosen level");

  // block returns to idle after the final result
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready && !out_valid)
    else $error("not idle after final result");

endmodule

bind multicore_realtime_priority_dispatcher_top mrpd_checker u_mrpd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (cmd.ready),
  .out_valid   (dispatch.valid),
  .out_ready   (dispatch.ready),
  .cpu_index   (dispatch.cpu_index),
  .chosen_prio (dispatch.chosen_prio),
  .is_realtime (dispatch.is_realtime),
  .last        (dispatch.last)
);
